### hdl/conv3x3_clamped_edges_unit_defines.svh
// assertion macros used by the checker file
`ifndef CONV3X3_CLAMPED_EDGES_UNIT_DEFINES_SVH
`define CONV3X3_CLAMPED_EDGES_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define C3E_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define C3E_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/c3e_pkg.sv
`timescale 1ns / 1ps
package c3e_pkg;

    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int MAX_HEIGHT       = 4096;

    localparam int SAMPLE_W   = 8;
    localparam int NUM_CH     = 4;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int CC_W       = 3;
    localparam int KS_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int SUM_W      = 13;
    localparam int TAPS       = 9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SELECT = 3'd3;

    // register reset values
    localparam logic [FW_W-1:0] RST_FRAME_WIDTH   = 12'd2048;
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT  = 13'd1;
    localparam logic [CC_W-1:0] RST_CHANNEL_COUNT = 3'd3;
    localparam logic [KS_W-1:0] RST_KERNEL_SELECT = 3'd5;

    // kernel codes
    localparam logic [KS_W-1:0] KS_EDGE     = 3'd0;
    localparam logic [KS_W-1:0] KS_SHARPEN  = 3'd1;
    localparam logic [KS_W-1:0] KS_BOX      = 3'd2;
    localparam logic [KS_W-1:0] KS_GAUSS    = 3'd3;
    localparam logic [KS_W-1:0] KS_EMBOSS   = 3'd4;
    localparam logic [KS_W-1:0] KS_IDENTITY = 3'd5;

    // commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // floor(s/9) as (s*3641)>>15, exact for s below 4096
    localparam int DIV9_MUL    = 3641;
    localparam int DIV9_SHIFT  = 15;
    localparam int GAUSS_SHIFT = 4;

    typedef logic signed [3:0] t_coef;

    // taps in row-major order, newest column last
    localparam t_coef COEF_TAB [0:5][0:TAPS-1] = '{
        '{ 4'sd0, -4'sd1,  4'sd0, -4'sd1, 4'sd4, -4'sd1,  4'sd0, -4'sd1, 4'sd0},
        '{ 4'sd0, -4'sd1,  4'sd0, -4'sd1, 4'sd5, -4'sd1,  4'sd0, -4'sd1, 4'sd0},
        '{ 4'sd1,  4'sd1,  4'sd1,  4'sd1, 4'sd1,  4'sd1,  4'sd1,  4'sd1, 4'sd1},
        '{ 4'sd1,  4'sd2,  4'sd1,  4'sd2, 4'sd4,  4'sd2,  4'sd1,  4'sd2, 4'sd1},
        '{-4'sd2, -4'sd1,  4'sd0, -4'sd1, 4'sd1,  4'sd1,  4'sd0,  4'sd1, 4'sd2},
        '{ 4'sd0,  4'sd0,  4'sd0,  4'sd0, 4'sd1,  4'sd0,  4'sd0,  4'sd0, 4'sd0}
    };

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             eof;
    } t_meta;

    typedef struct packed {
        logic [NUM_CH-1:0][SAMPLE_W-1:0] ch;
        t_meta                           meta;
    } t_result;

endpackage

### hdl/c3e_line_ram.sv
`timescale 1ns / 1ps
module c3e_line_ram #(
    parameter int DEPTH  = c3e_pkg::DEF_MAX_WIDTH,
    parameter int DATA_W = c3e_pkg::SAMPLE_W * c3e_pkg::DEF_MAX_CHANNELS
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/c3e_lane.sv
`timescale 1ns / 1ps
module c3e_lane (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic [c3e_pkg::TAPS-1:0][c3e_pkg::SAMPLE_W-1:0] i_win,
    input  logic [c3e_pkg::KS_W-1:0]                      i_ks,
    output logic [c3e_pkg::SAMPLE_W-1:0]                  o_pix
);
    import c3e_pkg::*;

    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] r_sum;
    logic [SUM_W+11:0]       prod;
    logic signed [SUM_W-1:0] quot;

    // weighted sum of the nine taps
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < TAPS; k++) begin
            n_sum = n_sum + SUM_W'(COEF_TAB[i_ks][k]) * SUM_W'($signed({1'b0, i_win[k]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    // normalise blur kernels, then clamp to a byte
    always_comb begin
        prod = {12'b0, r_sum[SUM_W-2:0]} * (SUM_W+11)'(DIV9_MUL);
        quot = r_sum;
        case (i_ks)
            KS_BOX: begin
                if (!r_sum[SUM_W-1]) begin
                    quot = $signed(SUM_W'(prod >> DIV9_SHIFT));
                end
            end
            KS_GAUSS: begin
                if (!r_sum[SUM_W-1]) begin
                    quot = r_sum >>> GAUSS_SHIFT;
                end
            end
            default: begin
            end
        endcase
        if (quot[SUM_W-1]) begin
            o_pix = '0;
        end else if (quot > 13'sd255) begin
            o_pix = 8'd255;
        end else begin
            o_pix = quot[SAMPLE_W-1:0];
        end
    end

endmodule

### hdl/conv3x3_clamped_edges_unit.sv
`timescale 1ns / 1ps
// Streaming 3x3 convolution with replicated borders. Pixels (command 0) enter in raster
// order, one per clock unless the output stalls; a row-0 pixel gives no result, later
// pixels past column 0 give the output one row up and one column left, and the last column
// of a row past column 0 gives two results, so that pixel holds the input back while the
// second result leaves through the single output register. After the last pixel of a frame,
// each flush (command 1) returns one pixel of the bottom row; a flush with nothing pending
// is taken and gives nothing. The first result of an item passes stages b and c and is then
// offered from the output register. Each line store is kept in three copies, so the three
// neighbouring columns that a flush needs come from one memory read each; a short forwarding
// path covers a read of the entry being written.
// Lanes run per channel and per output slot; channels beyond channel_count read zero.
module conv3x3_clamped_edges_unit #(
    parameter int MAX_WIDTH    = c3e_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = c3e_pkg::DEF_MAX_CHANNELS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [c3e_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [c3e_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_command,
    input  logic [c3e_pkg::SAMPLE_W-1:0]     i_in_ch0,
    input  logic [c3e_pkg::SAMPLE_W-1:0]     i_in_ch1,
    input  logic [c3e_pkg::SAMPLE_W-1:0]     i_in_ch2,
    input  logic [c3e_pkg::SAMPLE_W-1:0]     i_in_ch3,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [c3e_pkg::SAMPLE_W-1:0]     o_out_ch0,
    output logic [c3e_pkg::SAMPLE_W-1:0]     o_out_ch1,
    output logic [c3e_pkg::SAMPLE_W-1:0]     o_out_ch2,
    output logic [c3e_pkg::SAMPLE_W-1:0]     o_out_ch3,
    output logic [c3e_pkg::COL_W-1:0]        o_out_col,
    output logic [c3e_pkg::ROW_W-1:0]        o_out_row,
    output logic                             o_last_of_run,
    output logic                             o_end_of_frame
);
    import c3e_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = SAMPLE_W * MAX_CHANNELS;
    localparam int NCOPY = 3;

    // configuration registers
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic [CC_W-1:0] r_channel_count;
    logic [KS_W-1:0] r_kernel_select;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= RST_FRAME_WIDTH;
            r_frame_height  <= RST_FRAME_HEIGHT;
            r_channel_count <= RST_CHANNEL_COUNT;
            r_kernel_select <= RST_KERNEL_SELECT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data[FH_W-1:0];
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CC_W-1:0];
                REG_KERNEL_SELECT: r_kernel_select <= i_cfg_data[KS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective register values
    logic [WW-1:0]    w_eff;
    logic [CW-1:0]    w_last;
    logic [FH_W-1:0]  h_eff;
    logic [ROW_W-1:0] h_last;
    logic [CC_W-1:0]  nch_eff;
    logic [KS_W-1:0]  ks_eff;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        w_last = CW'(w_eff - 1'b1);
        if (r_frame_height == '0) begin
            h_eff = FH_W'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h_eff = FH_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
        h_last = ROW_W'(h_eff - 1'b1);
        if (r_channel_count == '0) begin
            nch_eff = CC_W'(1);
        end else if (32'(r_channel_count) > MAX_CHANNELS) begin
            nch_eff = CC_W'(MAX_CHANNELS);
        end else begin
            nch_eff = r_channel_count;
        end
        ks_eff = (r_kernel_select > KS_IDENTITY) ? KS_IDENTITY : r_kernel_select;
    end

    // pipeline advance: output register free or draining without a second result
    logic    en;
    logic    acc;
    logic    r_out_valid;
    logic    r_pend_valid;
    t_result r_out;
    t_result r_pend;

    assign en         = !r_out_valid || (i_out_ready && !r_pend_valid);
    assign o_in_ready = en;
    assign acc        = i_in_valid && en;

    // input position and flush state
    logic [CW-1:0]    r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [CW-1:0]    r_flush_col;
    logic             r_flush_pend;
    logic             is_flush;
    logic             row_end;
    logic             frame_end;
    logic [CW-1:0]    f_col;
    logic [CW-1:0]    f_left;
    logic [CW-1:0]    f_right;
    logic             f_last;
    logic [CW-1:0]    rd_addr [NCOPY];

    assign is_flush  = i_command == CMD_FLUSH;
    assign row_end   = r_in_col >= w_last;
    assign frame_end = r_in_row >= h_last;
    assign f_col     = (r_flush_col > w_last) ? w_last : r_flush_col;
    assign f_left    = (f_col == '0) ? '0 : f_col - 1'b1;
    assign f_right   = (f_col >= w_last) ? w_last : f_col + 1'b1;
    assign f_last    = f_col == w_last;
    assign rd_addr[0] = is_flush ? f_left : r_in_col;
    assign rd_addr[1] = f_col;
    assign rd_addr[2] = f_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_flush_col  <= '0;
            r_flush_pend <= 1'b0;
        end else if (acc) begin
            if (!is_flush) begin
                r_flush_pend <= 1'b0;
                if (row_end) begin
                    r_in_col <= '0;
                    if (frame_end) begin
                        r_in_row     <= '0;
                        r_flush_pend <= 1'b1;
                        r_flush_col  <= '0;
                    end else begin
                        r_in_row <= r_in_row + 1'b1;
                    end
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end else if (r_flush_pend) begin
                if (f_last) begin
                    r_flush_pend <= 1'b0;
                end else begin
                    r_flush_col <= f_col + 1'b1;
                end
            end
        end
    end

    // result slots and positions for this item
    logic  n_e0;
    logic  n_e1;
    t_meta n_meta0;
    t_meta n_meta1;

    always_comb begin
        n_e0    = 1'b0;
        n_e1    = 1'b0;
        n_meta0 = '{col: COL_W'(r_in_col - 1'b1), row: ROW_W'(r_in_row - 1'b1),
                    last: !row_end, eof: 1'b0};
        n_meta1 = '{col: COL_W'(r_in_col), row: ROW_W'(r_in_row - 1'b1),
                    last: 1'b1, eof: 1'b0};
        if (is_flush) begin
            n_e0    = r_flush_pend;
            n_meta0 = '{col: COL_W'(f_col), row: h_last, last: 1'b1, eof: f_last};
        end else begin
            n_e0 = (r_in_row != '0) && (r_in_col != '0);
            n_e1 = (r_in_row != '0) && row_end;
        end
    end

    // input pixel packed by channel
    logic [NUM_CH-1:0][SAMPLE_W-1:0] in_samples;
    logic [PW-1:0]                   pix_in;

    assign in_samples = {i_in_ch3, i_in_ch2, i_in_ch1, i_in_ch0};
    assign pix_in     = PW'(in_samples);

    // stage b: memory read data arrives
    logic          rB_valid;
    logic          rB_is_pixel;
    logic          rB_row0;
    logic          rB_col0;
    logic [CW-1:0] rB_addr;
    logic [PW-1:0] rB_pix;
    logic          rB_e0;
    logic          rB_e1;
    t_meta         rB_meta0;
    t_meta         rB_meta1;
    logic          b_write;
    logic [PW-1:0] wr_up;
    logic [PW-1:0] wr_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rB_valid <= 1'b0;
        end else if (en) begin
            rB_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rB_is_pixel <= !is_flush;
            rB_row0     <= r_in_row == '0;
            rB_col0     <= r_in_col == '0;
            rB_addr     <= r_in_col;
            rB_pix      <= pix_in;
            rB_e0       <= n_e0;
            rB_e1       <= n_e1;
            rB_meta0    <= n_meta0;
            rB_meta1    <= n_meta1;
        end
    end

    assign b_write = rB_valid && rB_is_pixel;

    // line stores, three read copies each
    logic [PW-1:0]    up_q  [NCOPY];
    logic [PW-1:0]    mid_q [NCOPY];
    logic [PW-1:0]    up_rd [NCOPY];
    logic [PW-1:0]    mid_rd[NCOPY];
    logic [NCOPY-1:0] r_fwd_hit;
    logic [PW-1:0]    r_fwd_up;
    logic [PW-1:0]    r_fwd_mid;

    for (genvar k = 0; k < NCOPY; k++) begin : g_copy
        c3e_line_ram #(
            .DEPTH  (MAX_WIDTH),
            .DATA_W (PW)
        ) u_upper (
            .i_clk     (i_clk),
            .i_rd_en   (en),
            .i_rd_addr (rd_addr[k]),
            .o_rd_data (up_q[k]),
            .i_wr_en   (en && b_write),
            .i_wr_addr (rB_addr),
            .i_wr_data (wr_up)
        );
        c3e_line_ram #(
            .DEPTH  (MAX_WIDTH),
            .DATA_W (PW)
        ) u_middle (
            .i_clk     (i_clk),
            .i_rd_en   (en),
            .i_rd_addr (rd_addr[k]),
            .o_rd_data (mid_q[k]),
            .i_wr_en   (en && b_write),
            .i_wr_addr (rB_addr),
            .i_wr_data (wr_mid)
        );
        assign up_rd[k]  = r_fwd_hit[k] ? r_fwd_up  : up_q[k];
        assign mid_rd[k] = r_fwd_hit[k] ? r_fwd_mid : mid_q[k];
    end

    // forward a write that lands on an address read in the same clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= '0;
        end else if (en) begin
            for (int k = 0; k < NCOPY; k++) begin
                r_fwd_hit[k] <= b_write && (rB_addr == rd_addr[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fwd_up  <= wr_up;
            r_fwd_mid <= wr_mid;
        end
    end

    assign wr_up  = rB_row0 ? rB_pix : mid_rd[0];
    assign wr_mid = rB_pix;

    // 3x3 window, index row*3 + col with col 2 newest
    logic [PW-1:0] r_win [TAPS];
    logic [PW-1:0] n_win [TAPS];
    logic [PW-1:0] col_v [3];
    logic [PW-1:0] win_s [2][TAPS];

    always_comb begin
        col_v[0] = up_rd[0];
        col_v[1] = mid_rd[0];
        col_v[2] = rB_pix;
        for (int i = 0; i < 3; i++) begin
            if (rB_col0) begin
                n_win[i*3]     = col_v[i];
                n_win[i*3 + 1] = col_v[i];
            end else begin
                n_win[i*3]     = r_win[i*3 + 1];
                n_win[i*3 + 1] = r_win[i*3 + 2];
            end
            n_win[i*3 + 2] = col_v[i];
        end
        // slot 0: current window, or the flush window with the bottom row repeated
        for (int i = 0; i < TAPS; i++) begin
            win_s[0][i] = n_win[i];
        end
        if (!rB_is_pixel) begin
            for (int j = 0; j < 3; j++) begin
                win_s[0][j]     = up_rd[j];
                win_s[0][3 + j] = mid_rd[j];
                win_s[0][6 + j] = mid_rd[j];
            end
        end
        // slot 1: right border window at the end of a row
        for (int i = 0; i < 3; i++) begin
            win_s[1][i*3]     = n_win[i*3 + 1];
            win_s[1][i*3 + 1] = n_win[i*3 + 2];
            win_s[1][i*3 + 2] = n_win[i*3 + 2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && b_write && !rB_row0) begin
            for (int i = 0; i < TAPS; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    // lanes: one per slot and channel
    logic [1:0][NUM_CH-1:0][SAMPLE_W-1:0] lane_pix;

    for (genvar s = 0; s < 2; s++) begin : g_slot
        for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
            if (c < MAX_CHANNELS) begin : g_lane
                logic [TAPS-1:0][SAMPLE_W-1:0] lwin;
                for (genvar k = 0; k < TAPS; k++) begin : g_tap
                    assign lwin[k] = win_s[s][k][c*SAMPLE_W +: SAMPLE_W];
                end
                c3e_lane u_lane (
                    .i_clk (i_clk),
                    .i_en  (en),
                    .i_win (lwin),
                    .i_ks  (ks_eff),
                    .o_pix (lane_pix[s][c])
                );
            end else begin : g_none
                assign lane_pix[s][c] = '0;
            end
        end
    end

    // stage c: lane sums registered
    logic    rC_valid;
    logic    rC_e0;
    logic    rC_e1;
    t_meta   rC_meta0;
    t_meta   rC_meta1;
    t_result res0;
    t_result res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rC_valid <= 1'b0;
        end else if (en) begin
            rC_valid <= rB_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rC_e0    <= rB_e0;
            rC_e1    <= rB_e1;
            rC_meta0 <= rB_meta0;
            rC_meta1 <= rB_meta1;
        end
    end

    // merge lanes into results, unused channels read zero
    always_comb begin
        res0.meta = rC_meta0;
        res1.meta = rC_meta1;
        for (int c = 0; c < NUM_CH; c++) begin
            if (c < int'(nch_eff)) begin
                res0.ch[c] = lane_pix[0][c];
                res1.ch[c] = lane_pix[1][c];
            end else begin
                res0.ch[c] = '0;
                res1.ch[c] = '0;
            end
        end
    end

    // output register with one result held behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (en) begin
            r_out_valid  <= rC_valid && (rC_e0 || rC_e1);
            r_pend_valid <= rC_valid && rC_e0 && rC_e1;
        end else if (r_out_valid && i_out_ready) begin
            r_out_valid  <= 1'b1;
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out  <= rC_e0 ? res0 : res1;
            r_pend <= res1;
        end else if (r_out_valid && i_out_ready) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_ch0      = r_out.ch[0];
    assign o_out_ch1      = r_out.ch[1];
    assign o_out_ch2      = r_out.ch[2];
    assign o_out_ch3      = r_out.ch[3];
    assign o_out_col      = r_out.meta.col;
    assign o_out_row      = r_out.meta.row;
    assign o_last_of_run  = r_out.meta.last;
    assign o_end_of_frame = r_out.meta.eof;

endmodule

### hdl/c3e_checker.sv
`timescale 1ns / 1ps
`include "conv3x3_clamped_edges_unit_defines.svh"
module c3e_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_last_of_run,
    input logic o_end_of_frame
);

    // stalled result stays offered
    `C3E_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // the second result of a pixel follows at once and closes the run
    `C3E_ASSERT_NEXT(a_second_follows, o_out_valid && i_out_ready && !o_last_of_run, o_out_valid && o_last_of_run, "second result missing")

    // frame end is always the last result of its item
    `C3E_ASSERT_SAME(a_eof_last, o_out_valid && o_end_of_frame, o_last_of_run, "end of frame not last of run")

    // no new item while a second result is waiting
    `C3E_ASSERT_SAME(a_hold_input, o_out_valid && !o_last_of_run, !o_in_ready, "item taken with a result pending")

endmodule

bind conv3x3_clamped_edges_unit c3e_checker u_c3e_checker (.*);

### tb/sv/conv3x3_clamped_edges_unit_tb.sv
`timescale 1ns / 1ps
module conv3x3_clamped_edges_unit_tb;
    import c3e_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LINE_DEPTH = 2048;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_command;
    logic [SAMPLE_W-1:0]   i_in_ch0, i_in_ch1, i_in_ch2, i_in_ch3;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [SAMPLE_W-1:0]   o_out_ch0, o_out_ch1, o_out_ch2, o_out_ch3;
    logic [COL_W-1:0]      o_out_col;
    logic [ROW_W-1:0]      o_out_row;
    logic                  o_last_of_run;
    logic                  o_end_of_frame;

    conv3x3_clamped_edges_unit DUT (.*);

    // kernel weights, row-major, newest column last
    int weights [6][9] = '{
        '{ 0, -1, 0, -1, 4, -1, 0, -1, 0},
        '{ 0, -1, 0, -1, 5, -1, 0, -1, 0},
        '{ 1,  1, 1,  1, 1,  1, 1,  1, 1},
        '{ 1,  2, 1,  2, 4,  2, 1,  2, 1},
        '{-2, -1, 0, -1, 1,  1, 0,  1, 2},
        '{ 0,  0, 0,  0, 1,  0, 0,  0, 0}
    };

    // predictor state
    logic [31:0] line_top [LINE_DEPTH];
    logic [31:0] line_mid [LINE_DEPTH];
    logic [8:0][31:0] win_reg;
    int cur_col, cur_row, flush_pos;
    bit flush_armed;
    int cfg_width, cfg_height, cfg_chans, cfg_kernel;

    t_result pixels_due [$];

    int send_idle_pct, recv_idle_pct, hold_left;
    int mismatches, results_seen, pixels_sent, flushes_sent, stall_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_result filter_pixel(logic [8:0][31:0] win, int col, int row,
                                             bit last, bit eof);
        t_result r;
        int nch, ks, s;
        nch = cfg_chans < 1 ? 1 : (cfg_chans > 4 ? 4 : cfg_chans);
        ks = cfg_kernel > 5 ? 5 : cfg_kernel;
        for (int ch = 0; ch < 4; ch++) begin
            s = 0;
            if (ch < nch) begin
                for (int k = 0; k < 9; k++)
                    s += weights[ks][k] * int'(win[k][8*ch +: 8]);
                if (ks == int'(KS_BOX) && s >= 0) s = s / 9;
                if (ks == int'(KS_GAUSS) && s >= 0) s = s / 16;
                if (s < 0) s = 0;
                if (s > 255) s = 255;
            end
            r.ch[ch] = s[7:0];
        end
        r.meta.col = col[COL_W-1:0];
        r.meta.row = row[ROW_W-1:0];
        r.meta.last = last;
        r.meta.eof = eof;
        return r;
    endfunction

    // advance the predictor by one accepted item
    task automatic predict_item(input logic cmd, input logic [31:0] pix);
        int w, h, f, l, r, c, rw, idx;
        bit row_end;
        logic [31:0] v;
        logic [8:0][31:0] win;
        w = cfg_width < 1 ? 1 : (cfg_width > LINE_DEPTH ? LINE_DEPTH : cfg_width);
        h = cfg_height < 1 ? 1 : (cfg_height > MAX_HEIGHT ? MAX_HEIGHT : cfg_height);
        if (cmd == CMD_FLUSH) begin
            if (!flush_armed) return;
            f = flush_pos > w - 1 ? w - 1 : flush_pos;
            l = f > 0 ? f - 1 : 0;
            r = f + 1 <= w - 1 ? f + 1 : w - 1;
            win[0] = line_top[l]; win[1] = line_top[f]; win[2] = line_top[r];
            win[3] = line_mid[l]; win[4] = line_mid[f]; win[5] = line_mid[r];
            win[6] = win[3]; win[7] = win[4]; win[8] = win[5];
            pixels_due.push_back(filter_pixel(win, f, h - 1, 1'b1, f == w - 1));
            if (f == w - 1) flush_armed = 0;
            else flush_pos = f + 1;
            return;
        end
        c = cur_col;
        rw = cur_row;
        idx = c < LINE_DEPTH ? c : LINE_DEPTH - 1;
        row_end = c >= w - 1;
        flush_armed = 0;
        if (rw == 0) begin
            line_top[idx] = pix;
            line_mid[idx] = pix;
        end else begin
            for (int i = 0; i < 3; i++) begin
                v = i == 0 ? line_top[idx] : (i == 1 ? line_mid[idx] : pix);
                if (c == 0) begin
                    win_reg[i*3] = v;
                    win_reg[i*3+1] = v;
                end else begin
                    win_reg[i*3] = win_reg[i*3+1];
                    win_reg[i*3+1] = win_reg[i*3+2];
                end
                win_reg[i*3+2] = v;
            end
            line_top[idx] = line_mid[idx];
            line_mid[idx] = pix;
            if (c >= 1)
                pixels_due.push_back(filter_pixel(win_reg, c - 1, rw - 1, !row_end, 1'b0));
            if (row_end) begin
                for (int i = 0; i < 3; i++) begin
                    win[i*3] = win_reg[i*3+1];
                    win[i*3+1] = win_reg[i*3+2];
                    win[i*3+2] = win_reg[i*3+2];
                end
                pixels_due.push_back(filter_pixel(win, c, rw - 1, 1'b1, 1'b0));
            end
        end
        if (row_end) begin
            cur_col = 0;
            if (rw >= h - 1) begin
                cur_row = 0;
                flush_armed = 1;
                flush_pos = 0;
            end else begin
                cur_row = rw + 1;
            end
        end else begin
            cur_col = c + 1;
        end
    endtask

    // offer one item, with random gaps before it
    task automatic send_item(input logic cmd, input logic [31:0] pix);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        {i_in_ch3, i_in_ch2, i_in_ch1, i_in_ch0} <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        predict_item(cmd, pix);
        if (cmd == CMD_FLUSH) flushes_sent++;
        else pixels_sent++;
    endtask

    task automatic send_pixel(input logic [31:0] pix);
        send_item(CMD_PIXEL, pix);
    endtask

    task automatic send_flush();
        send_item(CMD_FLUSH, $urandom());
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FRAME_WIDTH:   cfg_width = val & 12'hFFF;
            REG_FRAME_HEIGHT:  cfg_height = val & 13'h1FFF;
            REG_CHANNEL_COUNT: cfg_chans = val & 3'h7;
            REG_KERNEL_SELECT: cfg_kernel = val & 3'h7;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic setup_frame(input int w, input int h, input int nch, input int ks);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_CHANNEL_COUNT, nch);
        write_reg(REG_KERNEL_SELECT, ks);
    endtask

    // reset-time settings: the wide row must not end early, then it is cut short
    task automatic test_reset_defaults();
        repeat (5) send_pixel($urandom());
        drain();
        write_reg(REG_FRAME_WIDTH, 3);
        send_pixel($urandom());
        repeat (3) send_flush();
    endtask

    // every kernel code on a one-column frame, samples at both extremes
    task automatic test_all_kernels();
        logic [31:0] hi, lo;
        for (int k = 0; k < 8; k++) begin
            hi = k[0] ? 32'hFFFF_FFFF : 32'h55AA_00FF;
            lo = k[0] ? 32'h0000_0000 : 32'hAA55_FF00;
            setup_frame(1, 2, k % 5, k);
            send_pixel(hi);
            send_pixel(lo);
            send_flush();
        end
    endtask

    // stray flush, pixel that cancels flushing, flush once finished
    task automatic test_flush_cases();
        setup_frame(3, 2, 4, KS_SHARPEN);
        send_flush();
        repeat (6) send_pixel($urandom());
        send_flush();
        repeat (3) send_pixel(32'hFFFF_FFFF);
        repeat (3) send_pixel(32'h0000_0000);
        repeat (3) send_flush();
        send_flush();
    endtask

    // out-of-range register values
    task automatic test_register_clamps();
        setup_frame(0, 0, 0, 6);
        send_pixel($urandom());
        send_flush();
        // oversize width and height: neither row nor frame may end early
        setup_frame(4095, 8191, 7, KS_EDGE);
        repeat (8) send_pixel($urandom());
        drain();
        write_reg(REG_FRAME_WIDTH, 4);
        write_reg(REG_FRAME_HEIGHT, 2);
        repeat (5) send_pixel($urandom());
        repeat (5) send_flush();
    endtask

    // shrink width and height while a frame is open
    task automatic test_midframe_resize();
        setup_frame(6, 5, 4, KS_EMBOSS);
        repeat (15) send_pixel($urandom());
        drain();
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        repeat (4) send_pixel($urandom());
        repeat (4) send_flush();
    endtask

    // well-formed frames with random content and some noise
    task automatic run_frame(input int w, input int h);
        int nflush;
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(99) < 4) send_flush();
            send_pixel($urandom());
        end
        case ($urandom_range(9))
            0: nflush = $urandom_range(w);
            1: nflush = w + $urandom_range(3, 1);
            default: nflush = w;
        endcase
        repeat (nflush) send_flush();
    endtask

    task automatic test_random_frames(input int items, input bit with_holdoff);
        int w, h, sel, target;
        bit first;
        first = 1;
        target = pixels_sent + flushes_sent + items;
        while (pixels_sent + flushes_sent < target) begin
            sel = $urandom_range(99);
            w = sel < 80 ? $urandom_range(8, 1) :
                (sel < 98 ? $urandom_range(40, 9) : $urandom_range(200, 41));
            h = $urandom_range(5, 1);
            if (first || $urandom_range(99) < 60) begin
                setup_frame(w, h, $urandom_range(7), $urandom_range(7));
            end else begin
                w = cfg_width < 1 ? 1 : cfg_width;
                h = cfg_height < 1 ? 1 : cfg_height;
            end
            if (first && with_holdoff) hold_left = 400;
            first = 0;
            run_frame(w, h);
        end
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pixels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result col %0d row %0d", o_out_col, o_out_row);
            end else begin
                want = pixels_due.pop_front();
                if (o_out_ch0 !== want.ch[0] || o_out_ch1 !== want.ch[1] ||
                    o_out_ch2 !== want.ch[2] || o_out_ch3 !== want.ch[3] ||
                    o_out_col !== want.meta.col || o_out_row !== want.meta.row ||
                    o_last_of_run !== want.meta.last ||
                    o_end_of_frame !== want.meta.eof) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("exp ch %h %h %h %h col %0d row %0d last %b eof %b",
                                 want.ch[0], want.ch[1], want.ch[2], want.ch[3],
                                 want.meta.col, want.meta.row, want.meta.last,
                                 want.meta.eof);
                        $display("got ch %h %h %h %h col %0d row %0d last %b eof %b",
                                 o_out_ch0, o_out_ch1, o_out_ch2, o_out_ch3,
                                 o_out_col, o_out_row, o_last_of_run, o_end_of_frame);
                    end
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // watchdog on cycles without any input, output or configuration handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("conv3x3_clamped_edges_unit: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = CMD_PIXEL;
        {i_in_ch3, i_in_ch2, i_in_ch1, i_in_ch0} = '0;
        i_out_ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 0;
        mismatches = 0;
        results_seen = 0;
        pixels_sent = 0;
        flushes_sent = 0;
        stall_cycles = 0;
        win_reg = '0;
        cur_col = 0;
        cur_row = 0;
        flush_pos = 0;
        flush_armed = 0;
        cfg_width = RST_FRAME_WIDTH;
        cfg_height = RST_FRAME_HEIGHT;
        cfg_chans = RST_CHANNEL_COUNT;
        cfg_kernel = RST_KERNEL_SELECT;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 33;
        recv_idle_pct = 88;
        test_reset_defaults();
        test_all_kernels();
        test_flush_cases();
        test_midframe_resize();
        test_random_frames(540, 0);
        send_idle_pct = 88;
        recv_idle_pct = 33;
        test_register_clamps();
        test_random_frames(540, 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(540, 1);
        drain();

        $display("covered %0d pixels and %0d flushes over all kernels and register extremes",
                 pixels_sent, flushes_sent);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("conv3x3_clamped_edges_unit: match");
        else
            $display("conv3x3_clamped_edges_unit: mismatch");
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/c3e_pkg.sv
hdl/c3e_line_ram.sv
hdl/c3e_lane.sv
hdl/conv3x3_clamped_edges_unit.sv
hdl/c3e_checker.sv
tb/sv/conv3x3_clamped_edges_unit_tb.sv
